FILE: rtl/core/multi_channel_blink_controller_assert.svh
// Assertion macros for the blink controller.
`ifndef MULTI_CHANNEL_BLINK_CONTROLLER_ASSERT_SVH
`define MULTI_CHANNEL_BLINK_CONTROLLER_ASSERT_SVH

`ifndef SYNTH
`define MCBC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define MCBC_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MCBC_ASSERT(label, prop, msg)
`define MCBC_ASSERT_RST(label, prop, msg)
`endif

`endif

FILE: rtl/core/mcbc_pkg.sv
// Types and constants of the blink controller.
package mcbc_pkg;

  typedef struct packed {
    logic [2:0]  op;
    logic [1:0]  channel_mask;
    logic [7:0]  blink_count;
    logic [7:0]  on_percent;
    logic [15:0] period_ms;
  } item_t;

  typedef struct packed {
    logic [1:0] pin_levels;
    logic [1:0] blinking_mask;
  } result_t;

  localparam logic [2:0] OP_ON     = 3'd0;
  localparam logic [2:0] OP_OFF    = 3'd1;
  localparam logic [2:0] OP_TOGGLE = 3'd2;
  localparam logic [2:0] OP_BLINK  = 3'd3;
  localparam logic [2:0] OP_TICK   = 3'd4;

  localparam int unsigned MASK_W        = 2;
  localparam logic [7:0]  PCT_FULL      = 8'd100;
  localparam logic [1:0]  PIN_POL_RESET = 2'b00;

  // register map: one register, index taken from paddr[2]
  localparam int unsigned ADDR_W       = 3;
  localparam int unsigned DATA_W       = 32;
  localparam logic        REG_POLARITY = 1'b0;

  // floor(share * period / 100) = (period * SCALE[share]) >> SCALE_SHIFT
  localparam int unsigned SCALE_SHIFT = 24;
  localparam int unsigned SCALE_W     = 24;
  localparam int unsigned PERIOD_W    = 16;
  localparam int unsigned PROD_W      = PERIOD_W + SCALE_W;

  localparam longint unsigned SCALE_ONE  = longint'(1) << SCALE_SHIFT;
  localparam longint unsigned SCALE_STEP = SCALE_ONE / longint'(PCT_FULL);
  localparam longint unsigned SCALE_REM  = SCALE_ONE % longint'(PCT_FULL);

  typedef logic [SCALE_W-1:0] scale_tab_t [128];

  // advance quotient and remainder of i * SCALE_ONE / 100, round up
  function automatic scale_tab_t build_phase_scale();
    scale_tab_t      tab;
    longint unsigned quot;
    longint unsigned rem;
    quot = 0;
    rem  = 0;
    for (int i = 0; i < 128; i++) begin
      tab[i] = SCALE_W'(quot + ((rem != 0) ? longint'(1) : longint'(0)));
      quot = quot + SCALE_STEP;
      rem  = rem + SCALE_REM;
      if (rem >= longint'(PCT_FULL)) begin
        rem  = rem - longint'(PCT_FULL);
        quot = quot + 1;
      end
    end
    return tab;
  endfunction

  localparam scale_tab_t PHASE_SCALE = build_phase_scale();

endpackage

FILE: rtl/core/multi_channel_blink_controller.sv
// Multi-channel blink controller: on, off, toggle, blink and tick commands per channel.
// A word is held in the stage register, then its result word in the result register.
// One word per cycle unless result_ready stalls; each channel has its own multiplier.
// Reset: all channels off and not blinking, pins active low, pipeline empty.
`include "multi_channel_blink_controller_assert.svh"
module multi_channel_blink_controller
  import mcbc_pkg::*;
#(
  parameter int unsigned CHANNELS = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  item_t             item,
  output logic              result_valid,
  input  logic              result_ready,
  output result_t           result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic                 stage_valid;
  item_t                stage_item;
  logic [MASK_W-1:0]    pin_polarity;

  logic [CHANNELS-1:0]  chan_on;
  logic [CHANNELS-1:0]  chan_blinking;
  logic [CHANNELS-1:0]  chan_forever;
  logic [7:0]           blinks_left [CHANNELS];
  logic [6:0]           duty_share  [CHANNELS];
  logic [15:0]          period_len  [CHANNELS];
  logic [15:0]          wait_left   [CHANNELS];

  logic [CHANNELS-1:0]  chan_on_next;
  logic [CHANNELS-1:0]  chan_blinking_next;
  logic [CHANNELS-1:0]  chan_forever_next;
  logic [7:0]           blinks_left_next [CHANNELS];
  logic [6:0]           duty_share_next  [CHANNELS];
  logic [15:0]          period_len_next  [CHANNELS];
  logic [15:0]          wait_left_next   [CHANNELS];

  logic [6:0]           share     [CHANNELS];
  logic [PROD_W-1:0]    prod      [CHANNELS];
  logic [15:0]          phase_len [CHANNELS];
  logic [15:0]          wait_dec  [CHANNELS];

  logic [CHANNELS-1:0]  sel;
  logic                 blink_off;
  logic                 blink_on;
  logic                 advance;
  logic                 fire;
  logic                 cfg_write;
  result_t              result_next;

  assign advance    = !result_valid || result_ready;
  assign item_ready = !stage_valid || advance;
  assign fire       = stage_valid && advance;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_POLARITY);
  assign prdata    = (paddr[2] == REG_POLARITY) ? DATA_W'(pin_polarity) : '0;

  assign sel       = CHANNELS'(stage_item.channel_mask);
  assign blink_off = (sel == '0) || (stage_item.on_percent == '0) ||
                     (stage_item.period_ms == '0);
  assign blink_on  = stage_item.on_percent >= PCT_FULL;

  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      share[i]     = chan_on[i] ? 7'(PCT_FULL - 8'(duty_share[i])) : duty_share[i];
      prod[i]      = PROD_W'(period_len[i]) * PROD_W'(PHASE_SCALE[share[i]]);
      phase_len[i] = prod[i][PROD_W-1:SCALE_SHIFT];
      wait_dec[i]  = (wait_left[i] != '0) ? wait_left[i] - 16'd1 : '0;
    end
  end

  always_comb begin
    chan_on_next       = chan_on;
    chan_blinking_next = chan_blinking;
    chan_forever_next  = chan_forever;
    blinks_left_next   = blinks_left;
    duty_share_next    = duty_share;
    period_len_next    = period_len;
    wait_left_next     = wait_left;
    for (int i = 0; i < CHANNELS; i++) begin
      unique case (stage_item.op)
        OP_ON, OP_OFF: begin
          if (sel[i]) begin
            chan_on_next[i]       = (stage_item.op == OP_ON);
            chan_blinking_next[i] = 1'b0;
            chan_forever_next[i]  = 1'b0;
          end
        end
        OP_TOGGLE: begin
          if (sel[i]) begin
            chan_on_next[i] = !chan_on[i];
          end
        end
        OP_BLINK: begin
          if (sel[i]) begin
            if (blink_off || blink_on) begin
              chan_on_next[i]       = !blink_off;
              chan_blinking_next[i] = 1'b0;
              chan_forever_next[i]  = 1'b0;
            end else begin
              chan_on_next[i]       = 1'b0;
              chan_blinking_next[i] = 1'b1;
              chan_forever_next[i]  = (stage_item.blink_count == '0);
              blinks_left_next[i]   = stage_item.blink_count;
              duty_share_next[i]    = stage_item.on_percent[6:0];
              period_len_next[i]    = stage_item.period_ms;
              wait_left_next[i]     = '0;
            end
          end
        end
        OP_TICK: begin
          if (chan_blinking[i]) begin
            if (wait_dec[i] != '0) begin
              wait_left_next[i] = wait_dec[i];
            end else if (chan_on[i]) begin
              chan_on_next[i]   = 1'b0;
              wait_left_next[i] = phase_len[i];
              if (!chan_forever[i]) begin
                blinks_left_next[i] = 8'(blinks_left[i] - 8'd1);
              end
            end else if ((blinks_left[i] == '0) && !chan_forever[i]) begin
              chan_blinking_next[i] = 1'b0;
              wait_left_next[i]     = wait_dec[i];
            end else begin
              chan_on_next[i]   = 1'b1;
              wait_left_next[i] = phase_len[i];
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    result_next = '0;
    for (int i = 0; i < MASK_W; i++) begin
      if (i < CHANNELS) begin
        result_next.pin_levels[i]    = pin_polarity[i] ? chan_on_next[i] : !chan_on_next[i];
        result_next.blinking_mask[i] = chan_blinking_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid   <= 1'b0;
      result_valid  <= 1'b0;
      pin_polarity  <= PIN_POL_RESET;
      chan_on       <= '0;
      chan_blinking <= '0;
      chan_forever  <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        blinks_left[i] <= '0;
        duty_share[i]  <= '0;
        period_len[i]  <= '0;
        wait_left[i]   <= '0;
      end
    end else begin
      if (cfg_write) begin
        pin_polarity <= pwdata[MASK_W-1:0];
      end
      if (item_ready) begin
        stage_valid <= item_valid;
      end
      if (advance) begin
        result_valid <= stage_valid;
      end
      if (fire) begin
        chan_on       <= chan_on_next;
        chan_blinking <= chan_blinking_next;
        chan_forever  <= chan_forever_next;
        blinks_left   <= blinks_left_next;
        duty_share    <= duty_share_next;
        period_len    <= period_len_next;
        wait_left     <= wait_left_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      stage_item <= item;
    end
    if (fire) begin
      result <= result_next;
    end
  end

  `MCBC_ASSERT_RST(a_reset_empties, rst |=> !stage_valid && !result_valid, "busy after reset")
  `MCBC_ASSERT(a_forever_blinks, (chan_forever & ~chan_blinking) == '0, "forever not blinking")
  `MCBC_ASSERT(a_stage_holds, !item_ready |=> stage_valid && $stable(stage_item), "stall lost")
  `MCBC_ASSERT(a_result_from_stage, $rose(result_valid) |-> $past(stage_valid), "stray result")

endmodule
